// ----- rtl/wbeu_pkg.sv -----
`timescale 1ns / 1ps
package wbeu_pkg;

    localparam int ENGINE_COUNT_DEF = 8;
    localparam int RING_DEPTH_DEF   = 64;

    localparam int TS_W    = 48;
    localparam int ENG_W   = 3;
    localparam int LEVEL_W = 16;
    localparam int DUR_W   = 32;
    localparam int TOTAL_W = 34;
    localparam int SUM_W   = 48;
    localparam int QUO_W   = 16;
    localparam int OUT_W   = 15;

    localparam logic [DUR_W-1:0]   WINDOW_RESET = 32'd10000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 16'hFFFF;
    localparam logic [OUT_W-1:0]   FULL_SCALE   = 15'd25600;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_FIRST,
        OP_ELAPSED,
        OP_DROP_RD,
        OP_DROP,
        OP_WRITE,
        OP_WLEV,
        OP_TRIM_RD,
        OP_TRIM,
        OP_CALC_INIT,
        OP_C_RD,
        OP_C_MUL,
        OP_C_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ENG_DONE,
        OP_FIN,
        OP_FIN_ZERO
    } dp_op_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic started;
        logic later;
        logic full;
        logic lev_last;
        logic trim_need;
        logic total_zero;
        logic ent_last;
        logic div_last;
        logic eng_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/wbeu_ram.sv -----
`timescale 1ns / 1ps
module wbeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/wbeu_ctrl.sv -----
`timescale 1ns / 1ps
module wbeu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    input  wbeu_pkg::dp_status_t  status,
    output wbeu_pkg::dp_op_t      op,
    output logic                  s_tready
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DROP_RD,
        ST_DROP,
        ST_WRITE,
        ST_WLEV,
        ST_TRIM_CHK,
        ST_TRIM_RD,
        ST_TRIM,
        ST_CALC_INIT,
        ST_C_RD,
        ST_C_MUL,
        ST_C_ACC,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_ENG_DONE,
        ST_FIN,
        ST_FIN_ZERO
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and operation decode
    always_comb
    begin
        state_next = state_reg;
        op         = wbeu_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.started)
                begin
                    op         = wbeu_pkg::OP_FIRST;
                    state_next = ST_FIN_ZERO;
                end
                else if (!status.later)
                begin
                    state_next = ST_FIN_ZERO;
                end
                else
                begin
                    op         = wbeu_pkg::OP_ELAPSED;
                    state_next = status.full ? ST_DROP_RD : ST_WRITE;
                end
            end
            ST_DROP_RD:
            begin
                op         = wbeu_pkg::OP_DROP_RD;
                state_next = ST_DROP;
            end
            ST_DROP:
            begin
                op         = wbeu_pkg::OP_DROP;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                op         = wbeu_pkg::OP_WRITE;
                state_next = ST_WLEV;
            end
            ST_WLEV:
            begin
                op = wbeu_pkg::OP_WLEV;
                if (status.lev_last)
                begin
                    state_next = ST_TRIM_CHK;
                end
            end
            ST_TRIM_CHK:
            begin
                if (status.trim_need)
                begin
                    state_next = ST_TRIM_RD;
                end
                else if (status.total_zero)
                begin
                    state_next = ST_FIN_ZERO;
                end
                else
                begin
                    state_next = ST_CALC_INIT;
                end
            end
            ST_TRIM_RD:
            begin
                op         = wbeu_pkg::OP_TRIM_RD;
                state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                op         = wbeu_pkg::OP_TRIM;
                state_next = ST_TRIM_CHK;
            end
            ST_CALC_INIT:
            begin
                op         = wbeu_pkg::OP_CALC_INIT;
                state_next = ST_C_RD;
            end
            ST_C_RD:
            begin
                op         = wbeu_pkg::OP_C_RD;
                state_next = ST_C_MUL;
            end
            ST_C_MUL:
            begin
                op         = wbeu_pkg::OP_C_MUL;
                state_next = ST_C_ACC;
            end
            ST_C_ACC:
            begin
                op         = wbeu_pkg::OP_C_ACC;
                state_next = status.ent_last ? ST_DIV_INIT : ST_C_RD;
            end
            ST_DIV_INIT:
            begin
                op         = wbeu_pkg::OP_DIV_INIT;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                op = wbeu_pkg::OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_ENG_DONE;
                end
            end
            ST_ENG_DONE:
            begin
                op         = wbeu_pkg::OP_ENG_DONE;
                state_next = status.eng_last ? ST_FIN : ST_C_RD;
            end
            ST_FIN:
            begin
                op = wbeu_pkg::OP_FIN;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_ZERO:
            begin
                op = wbeu_pkg::OP_FIN_ZERO;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/wbeu_dp.sv -----
`timescale 1ns / 1ps
module wbeu_dp #(
    parameter int ENGINE_COUNT = wbeu_pkg::ENGINE_COUNT_DEF,
    parameter int RING_DEPTH   = wbeu_pkg::RING_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_fire,
    input  logic [wbeu_pkg::TS_W-1:0]         sample_time,
    input  logic [wbeu_pkg::ENG_W-1:0]        engine_index,
    input  logic [wbeu_pkg::LEVEL_W-1:0]      utilization,
    input  logic                              sample_valid,
    input  logic                              cfg_fire,
    input  logic [wbeu_pkg::DUR_W-1:0]        cfg_data,
    input  wbeu_pkg::dp_op_t                  op,
    input  logic                              m_tready,
    output wbeu_pkg::dp_status_t              status,
    output logic                              m_tvalid,
    output logic [wbeu_pkg::OUT_W-1:0]        busiest_utilization
);

    localparam int DW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int EW = (ENGINE_COUNT > 1) ? $clog2(ENGINE_COUNT) : 1;
    localparam int LD = RING_DEPTH * ENGINE_COUNT;
    localparam int LW = (LD > 1) ? $clog2(LD) : 1;
    localparam int DSH_W = wbeu_pkg::TOTAL_W + wbeu_pkg::QUO_W - 1;
    localparam int STEP_W = $clog2(wbeu_pkg::QUO_W);

    logic [wbeu_pkg::DUR_W-1:0]   window_reg;
    logic [wbeu_pkg::DUR_W-1:0]   win_eff;
    logic [wbeu_pkg::TS_W-1:0]    ts_reg;
    logic                         started_reg;
    logic [wbeu_pkg::TS_W-1:0]    prev_reg;
    logic [wbeu_pkg::LEVEL_W-1:0] acc_reg [ENGINE_COUNT];
    logic [wbeu_pkg::DUR_W-1:0]   elapsed_reg;
    logic [DW-1:0]                head_reg;
    logic [CW-1:0]                count_reg;
    logic [wbeu_pkg::TOTAL_W-1:0] total_reg;
    logic [DW-1:0]                slot_reg;
    logic [EW-1:0]                e_reg;
    logic [CW-1:0]                i_reg;
    logic [DW-1:0]                ptr_reg;
    logic [wbeu_pkg::SUM_W-1:0]   sum_reg;
    logic [wbeu_pkg::SUM_W-1:0]   prod_reg;
    logic [wbeu_pkg::SUM_W-1:0]   rem_reg;
    logic [DSH_W-1:0]             dsh_reg;
    logic [wbeu_pkg::QUO_W-1:0]   quo_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [wbeu_pkg::QUO_W-1:0]   best_reg;
    logic                         out_valid_reg;
    logic [wbeu_pkg::OUT_W-1:0]   out_data_reg;

    logic [wbeu_pkg::TS_W-1:0]    diff;
    logic [DW:0]                  slot_sum;
    logic [DW-1:0]                slot;
    logic [DW-1:0]                head_inc;
    logic [DW-1:0]                ptr_inc;
    logic [wbeu_pkg::TOTAL_W-1:0] excess;
    logic [wbeu_pkg::TOTAL_W-1:0] win_ext;
    logic [DSH_W-1:0]             rem_ext;
    logic                         out_free;

    logic                         dur_we;
    logic [DW-1:0]                dur_waddr;
    logic [wbeu_pkg::DUR_W-1:0]   dur_wdata;
    logic [DW-1:0]                dur_raddr;
    logic [wbeu_pkg::DUR_W-1:0]   dur_rdata;
    logic                         lev_we;
    logic [LW-1:0]                lev_waddr;
    logic [LW-1:0]                lev_raddr;
    logic [wbeu_pkg::LEVEL_W-1:0] lev_rdata;

    // ring arithmetic and derived values
    always_comb
    begin
        win_eff  = (window_reg == '0) ? wbeu_pkg::DUR_W'(1) : window_reg;
        win_ext  = wbeu_pkg::TOTAL_W'(win_eff);
        diff     = ts_reg - prev_reg;
        slot_sum = (DW + 1)'(head_reg) + (DW + 1)'(count_reg);
        slot     = (slot_sum >= (DW + 1)'(RING_DEPTH)) ?
                   DW'(slot_sum - (DW + 1)'(RING_DEPTH)) : DW'(slot_sum);
        head_inc = (head_reg == DW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        ptr_inc  = (ptr_reg == DW'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
        excess   = total_reg - win_ext;
        rem_ext  = DSH_W'(rem_reg);
        out_free = !out_valid_reg || m_tready;
    end

    // memory port selection
    always_comb
    begin
        dur_we    = (op == wbeu_pkg::OP_WRITE) ||
                    ((op == wbeu_pkg::OP_TRIM) &&
                     (wbeu_pkg::TOTAL_W'(dur_rdata) > excess));
        dur_waddr = (op == wbeu_pkg::OP_WRITE) ? slot : head_reg;
        dur_wdata = (op == wbeu_pkg::OP_WRITE) ? elapsed_reg :
                    dur_rdata - wbeu_pkg::DUR_W'(excess);
        dur_raddr = (op == wbeu_pkg::OP_C_RD) ? ptr_reg : head_reg;
        lev_we    = (op == wbeu_pkg::OP_WLEV);
        lev_waddr = LW'(slot_reg) * LW'(ENGINE_COUNT) + LW'(e_reg);
        lev_raddr = LW'(ptr_reg) * LW'(ENGINE_COUNT) + LW'(e_reg);
    end

    wbeu_ram #(
        .WIDTH (wbeu_pkg::DUR_W),
        .DEPTH (RING_DEPTH)
    ) u_dur_ram (
        .clk   (clk),
        .we    (dur_we),
        .waddr (dur_waddr),
        .wdata (dur_wdata),
        .raddr (dur_raddr),
        .rdata (dur_rdata)
    );

    wbeu_ram #(
        .WIDTH (wbeu_pkg::LEVEL_W),
        .DEPTH (LD)
    ) u_lev_ram (
        .clk   (clk),
        .we    (lev_we),
        .waddr (lev_waddr),
        .wdata (acc_reg[e_reg]),
        .raddr (lev_raddr),
        .rdata (lev_rdata)
    );

    // status to controller
    always_comb
    begin
        status.started    = started_reg;
        status.later      = ts_reg > prev_reg;
        status.full       = (count_reg == CW'(RING_DEPTH));
        status.lev_last   = (e_reg == EW'(ENGINE_COUNT - 1));
        status.trim_need  = (count_reg != '0) && (total_reg > win_ext);
        status.total_zero = (total_reg == '0);
        status.ent_last   = (i_reg == count_reg - 1'b1);
        status.div_last   = (step_reg == STEP_W'(wbeu_pkg::QUO_W - 1));
        status.eng_last   = (e_reg == EW'(ENGINE_COUNT - 1));
        status.out_free   = out_free;
    end

    // per-engine set accumulators, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENGINE_COUNT; e++)
            begin
                acc_reg[e] <= '0;
            end
        end
        else
        begin
            for (int e = 0; e < ENGINE_COUNT; e++)
            begin
                if (((op == wbeu_pkg::OP_FIN) || (op == wbeu_pkg::OP_FIN_ZERO)) && out_free)
                begin
                    acc_reg[e] <= '0;
                end
                else if (in_fire && sample_valid && (utilization != '0) &&
                         (7'(engine_index) == 7'(e)))
                begin
                    if ((17'(acc_reg[e]) + 17'(utilization)) > 17'(wbeu_pkg::LEVEL_MAX))
                    begin
                        acc_reg[e] <= wbeu_pkg::LEVEL_MAX;
                    end
                    else
                    begin
                        acc_reg[e] <= acc_reg[e] + utilization;
                    end
                end
            end
        end
    end

    // control state of the ring and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= wbeu_pkg::WINDOW_RESET;
            started_reg   <= 1'b0;
            prev_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                window_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                wbeu_pkg::OP_FIRST:
                begin
                    started_reg <= 1'b1;
                    prev_reg    <= ts_reg;
                end
                wbeu_pkg::OP_ELAPSED:
                begin
                    prev_reg <= ts_reg;
                end
                wbeu_pkg::OP_DROP:
                begin
                    total_reg <= total_reg - wbeu_pkg::TOTAL_W'(dur_rdata);
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                end
                wbeu_pkg::OP_WRITE:
                begin
                    count_reg <= count_reg + 1'b1;
                    total_reg <= total_reg + wbeu_pkg::TOTAL_W'(elapsed_reg);
                end
                wbeu_pkg::OP_TRIM:
                begin
                    if (wbeu_pkg::TOTAL_W'(dur_rdata) <= excess)
                    begin
                        total_reg <= total_reg - wbeu_pkg::TOTAL_W'(dur_rdata);
                        head_reg  <= head_inc;
                        count_reg <= count_reg - 1'b1;
                    end
                    else
                    begin
                        total_reg <= win_ext;
                    end
                end
                wbeu_pkg::OP_FIN, wbeu_pkg::OP_FIN_ZERO:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers: timestamp, sweep counters, multiply and divide
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ts_reg <= sample_time;
        end
        case (op)
            wbeu_pkg::OP_ELAPSED:
            begin
                elapsed_reg <= (diff > wbeu_pkg::TS_W'(win_eff)) ?
                               win_eff : wbeu_pkg::DUR_W'(diff);
            end
            wbeu_pkg::OP_WRITE:
            begin
                slot_reg <= slot;
                e_reg    <= '0;
            end
            wbeu_pkg::OP_WLEV:
            begin
                e_reg <= e_reg + 1'b1;
            end
            wbeu_pkg::OP_CALC_INIT:
            begin
                e_reg    <= '0;
                i_reg    <= '0;
                ptr_reg  <= head_reg;
                sum_reg  <= '0;
                best_reg <= '0;
            end
            wbeu_pkg::OP_C_MUL:
            begin
                prod_reg <= wbeu_pkg::SUM_W'(lev_rdata) * wbeu_pkg::SUM_W'(dur_rdata);
            end
            wbeu_pkg::OP_C_ACC:
            begin
                sum_reg <= sum_reg + prod_reg;
                i_reg   <= i_reg + 1'b1;
                ptr_reg <= ptr_inc;
            end
            wbeu_pkg::OP_DIV_INIT:
            begin
                rem_reg  <= sum_reg;
                dsh_reg  <= DSH_W'(total_reg) << (wbeu_pkg::QUO_W - 1);
                quo_reg  <= '0;
                step_reg <= '0;
            end
            wbeu_pkg::OP_DIV_STEP:
            begin
                if (rem_ext >= dsh_reg)
                begin
                    rem_reg <= wbeu_pkg::SUM_W'(rem_ext - dsh_reg);
                    quo_reg <= {quo_reg[wbeu_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[wbeu_pkg::QUO_W-2:0], 1'b0};
                end
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg + 1'b1;
            end
            wbeu_pkg::OP_ENG_DONE:
            begin
                if (quo_reg > best_reg)
                begin
                    best_reg <= quo_reg;
                end
                e_reg   <= e_reg + 1'b1;
                i_reg   <= '0;
                ptr_reg <= head_reg;
                sum_reg <= '0;
            end
            wbeu_pkg::OP_FIN:
            begin
                if (out_free)
                begin
                    out_data_reg <= (best_reg > wbeu_pkg::QUO_W'(wbeu_pkg::FULL_SCALE)) ?
                                    wbeu_pkg::FULL_SCALE : wbeu_pkg::OUT_W'(best_reg);
                end
            end
            wbeu_pkg::OP_FIN_ZERO:
            begin
                if (out_free)
                begin
                    out_data_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid            = out_valid_reg;
    assign busiest_utilization = out_data_reg;

endmodule

// ----- rtl/windowed_busiest_engine_utilization_top.sv -----
`timescale 1ns / 1ps
// an item without tlast is taken back to back; an item with tlast closes the set: if its time
// is later than the last, the elapsed time is written to the ring (oldest entry dropped when
// full), the ring is trimmed to the window, each engine is swept and divided; else zero is sent
// throughput: one set at a time; a closing set also waits while the previous word is unread
// reset: rst_n asynchronous active low; window 10000 ms, ring empty, accumulators clear,
// ring memories hold no reset value and need no clearing pass
module windowed_busiest_engine_utilization_top #(
    parameter int ENGINE_COUNT = wbeu_pkg::ENGINE_COUNT_DEF,
    parameter int RING_DEPTH   = wbeu_pkg::RING_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // sample_time[47:0], engine_index[50:48], utilization[66:51]
    input  logic [0:0]  s_tuser,   // sample_valid[0]
    input  logic        s_tlast,   // last_of_set
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // busiest_utilization[14:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // window_length_ms
);

    wbeu_pkg::dp_op_t     op;
    wbeu_pkg::dp_status_t status;
    logic                 in_fire;
    logic [wbeu_pkg::OUT_W-1:0] busiest;

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, busiest};

    // sequencer
    wbeu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .status   (status),
        .op       (op),
        .s_tready (s_tready)
    );

    // ring, accumulators, multiply and divide
    wbeu_dp #(
        .ENGINE_COUNT (ENGINE_COUNT),
        .RING_DEPTH   (RING_DEPTH)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_fire             (in_fire),
        .sample_time         (s_tdata[47:0]),
        .engine_index        (s_tdata[50:48]),
        .utilization         (s_tdata[66:51]),
        .sample_valid        (s_tuser[0]),
        .cfg_fire            (cfg_valid && cfg_ready),
        .cfg_data            (cfg_data),
        .op                  (op),
        .m_tready            (m_tready),
        .status              (status),
        .m_tvalid            (m_tvalid),
        .busiest_utilization (busiest)
    );

    // closing a set always makes the block busy for a while
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input not stalled after closing a set");

    // result never exceeds full scale
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= 16'(wbeu_pkg::FULL_SCALE)))
        else $error("result beyond full scale");

    // a new word only appears while the input side is stalled
    a_word_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("word produced without a closed set");

endmodule
